@@ src/osct_pkg.sv @@
`default_nettype none
package osct_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int SMP_W     = 18;
  localparam int SCORE_W   = 48;
  localparam int SC_W      = SCORE_W + 2;
  localparam int SUM_W     = SC_W + 1;
  localparam int G_W       = SMP_W + 3;
  localparam int IN_W      = G_W + 2;
  localparam int A_W       = 16;
  localparam int C_W       = 20;
  localparam int P_W       = A_W + 1 + IN_W;
  localparam int STEP      = 8192;

  localparam logic [2:0] REG_GAIN_A    = 3'd0;
  localparam logic [2:0] REG_PENALTY_C = 3'd1;
  localparam logic [2:0] REG_DIRECTION = 3'd2;
  localparam logic [2:0] REG_ROW_WIDTH = 3'd3;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    slice_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0]                best_column;
    logic signed [SCORE_W-1:0] best_score;
  } out_word_t;

  typedef struct packed {
    logic                   vld;
    logic signed [SC_W-1:0] val;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic relax;
    logic flush;
  } chain_ctl_t;

endpackage
`default_nettype wire

@@ src/one_side_contour_dp_trellis_unit.sv @@
`default_nettype none
// Contour tracker over the rows of a slice. Takes one smoothed sample per word
// in raster order and returns one word per finished row: the first column of
// maximal cumulative score and that score. A sample that is column zero of
// its row is only stored; any other sample goes through PREP, MUL and SCORE,
// and the sample that closes its row goes through them twice, then waits in
// EMIT until the output register is free to hand off the word. Row-to-row
// score spreading runs in a chain of MAX_WIDTH cells that shift one column per
// scored column; at each row end the chain is realigned by shifting until the
// row has made MAX_WIDTH shifts and then relaxed. Input is held off during
// that pass; configuration stays open.
module one_side_contour_dp_trellis_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  osct_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output osct_pkg::out_word_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [2:0]           cfg_index,
  input  wire  [19:0]          cfg_data
);
  import osct_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SCORE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_ALIGN = 3'd5;
  localparam logic [2:0] ST_RELAX = 3'd6;

  logic [2:0]               st_r;
  logic [A_W-1:0]           gain_a_r;
  logic [C_W-1:0]           penalty_c_r;
  logic                     direction_r;
  logic [8:0]               row_width_r;
  logic signed [SMP_W-1:0]  hist0_r;
  logic signed [SMP_W-1:0]  hist1_r;
  logic [COL_W-1:0]         cnt_r;
  logic                     first_row_r;
  logic signed [SCORE_W-1:0] best_r;
  logic [COL_W-1:0]         best_col_r;
  logic [CNT_W-1:0]         sc_r;
  logic signed [G_W-1:0]    g0_r;
  logic signed [G_W-1:0]    g1_r;
  logic [COL_W-1:0]         k_r;
  logic                     end_r;
  logic                     phase_r;
  logic                     out_valid_r;
  out_word_t                out_r;

  logic                     in_acc;
  logic [CNT_W-1:0]         w_eff;
  logic [COL_W-1:0]         k_in;
  logic                     end_in;
  logic signed [SMP_W:0]    d0;
  logic signed [SMP_W:0]    d1;
  logic signed [G_W-1:0]    g_sel;
  logic [COL_W-1:0]         col_sel;
  logic signed [P_W-1:0]    product;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SCORE_W-1:0] score;
  chain_ctl_t               ctl;
  cell_t                    shift_in;
  cell_t                    head;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (row_width_r < 9'd3) begin
      w_eff = CNT_W'(3);
    end else if (int'(row_width_r) > MAX_WIDTH) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(row_width_r);
    end
    k_in   = in_data.slice_start ? '0 : cnt_r;
    end_in = (k_in != '0) && ((CNT_W'(k_in) + CNT_W'(1)) >= w_eff);
    d0     = {in_data.sample[SMP_W-1], in_data.sample} - {hist0_r[SMP_W-1], hist0_r};
    d1     = {in_data.sample[SMP_W-1], in_data.sample} - {hist1_r[SMP_W-1], hist1_r};
    if (phase_r || k_r == COL_W'(1)) begin
      g_sel = g0_r;
    end else begin
      g_sel = g1_r;
    end
    if (phase_r) begin
      col_sel = k_r;
    end else if (k_r == COL_W'(1)) begin
      col_sel = '0;
    end else begin
      col_sel = k_r - COL_W'(1);
    end
  end

  osct_gain u_gain (
    .clk      (clk),
    .g        (g_sel),
    .direction(direction_r),
    .penalty_c(penalty_c_r),
    .gain_a   (gain_a_r),
    .product  (product)
  );

  always_comb begin
    if (first_row_r) begin
      sum = SUM_W'(product);
    end else begin
      sum = SUM_W'($signed(head.val)) + SUM_W'(product);
    end
    if (sum[SUM_W-1:SCORE_W-1] == '0 || sum[SUM_W-1:SCORE_W-1] == '1) begin
      score = sum[SCORE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      score = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      score = {1'b0, {(SCORE_W-1){1'b1}}};
    end
    ctl.flush    = in_acc && in_data.slice_start;
    ctl.shift    = (st_r == ST_SCORE) ||
                   ((st_r == ST_ALIGN) && (sc_r != CNT_W'(MAX_WIDTH)));
    ctl.relax    = (st_r == ST_RELAX);
    shift_in.vld = (st_r == ST_SCORE);
    shift_in.val = SC_W'(score);
  end

  osct_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .shift_in(shift_in),
    .head    (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      gain_a_r    <= A_W'(256);
      penalty_c_r <= '0;
      direction_r <= 1'b1;
      row_width_r <= 9'd256;
      hist0_r     <= '0;
      hist1_r     <= '0;
      cnt_r       <= '0;
      first_row_r <= 1'b1;
      best_r      <= {1'b1, {(SCORE_W-1){1'b0}}};
      best_col_r  <= '0;
      sc_r        <= '0;
      out_valid_r <= 1'b0;
      end_r       <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_A:    gain_a_r    <= cfg_data[A_W-1:0];
          REG_PENALTY_C: penalty_c_r <= cfg_data[C_W-1:0];
          REG_DIRECTION: direction_r <= cfg_data[0];
          REG_ROW_WIDTH: row_width_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && st_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            hist1_r <= hist0_r;
            hist0_r <= in_data.sample;
            end_r   <= end_in;
            phase_r <= 1'b0;
            if (in_data.slice_start) begin
              first_row_r <= 1'b1;
              best_r      <= {1'b1, {(SCORE_W-1){1'b0}}};
              best_col_r  <= '0;
              sc_r        <= '0;
            end
            if (end_in) begin
              cnt_r <= '0;
            end else if (k_in < COL_W'(MAX_WIDTH - 1)) begin
              cnt_r <= k_in + COL_W'(1);
            end else begin
              cnt_r <= k_in;
            end
            if (k_in != '0) begin
              st_r <= ST_PREP;
            end
          end
        end
        ST_PREP:  st_r <= ST_MUL;
        ST_MUL:   st_r <= ST_SCORE;
        ST_SCORE: begin
          sc_r <= sc_r + CNT_W'(1);
          if (col_sel == '0 || score > best_r) begin
            best_r     <= score;
            best_col_r <= col_sel;
          end
          if (end_r && !phase_r) begin
            phase_r <= 1'b1;
            st_r    <= ST_PREP;
          end else if (end_r) begin
            st_r <= ST_EMIT;
          end else begin
            st_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            first_row_r          <= 1'b0;
            best_r               <= {1'b1, {(SCORE_W-1){1'b0}}};
            best_col_r           <= '0;
            st_r                 <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (sc_r == CNT_W'(MAX_WIDTH)) begin
            sc_r <= '0;
            st_r <= ST_RELAX;
          end else begin
            sc_r <= sc_r + CNT_W'(1);
          end
        end
        ST_RELAX: begin
          if (sc_r == CNT_W'(MAX_WIDTH - 2)) begin
            sc_r <= '0;
            st_r <= ST_IDLE;
          end else begin
            sc_r <= sc_r + CNT_W'(1);
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      k_r  <= k_in;
      g0_r <= {d0[SMP_W], d0, 1'b0};
      g1_r <= G_W'(d1);
    end
    if (st_r == ST_EMIT && (!out_valid_r || out_ready)) begin
      out_r.best_column <= 8'(best_col_r);
      out_r.best_score  <= best_r;
    end
  end

endmodule
`default_nettype wire

@@ src/osct_cell.sv @@
`default_nettype none
module osct_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  osct_pkg::chain_ctl_t ctl,
  input  osct_pkg::cell_t      up_i,
  input  osct_pkg::cell_t      dn_i,
  output osct_pkg::cell_t      q_o
);
  import osct_pkg::*;

  cell_t                  q_r;
  cell_t                  q_nxt;
  logic signed [SC_W-1:0] up_m;
  logic signed [SC_W-1:0] dn_m;

  always_comb begin
    up_m  = $signed(up_i.val) - SC_W'(STEP);
    dn_m  = $signed(dn_i.val) - SC_W'(STEP);
    q_nxt = q_r;
    if (ctl.flush) begin
      q_nxt.vld = 1'b0;
    end else if (ctl.shift) begin
      q_nxt = up_i;
    end else if (ctl.relax) begin
      if (up_i.vld && (!q_nxt.vld || up_m > $signed(q_nxt.val))) begin
        q_nxt.vld = 1'b1;
        q_nxt.val = up_m;
      end
      if (dn_i.vld && (!q_nxt.vld || dn_m > $signed(q_nxt.val))) begin
        q_nxt.vld = 1'b1;
        q_nxt.val = dn_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= q_nxt.vld;
    end
    q_r.val <= q_nxt.val;
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

@@ src/osct_chain.sv @@
`default_nettype none
module osct_chain (
  input  wire                  clk,
  input  wire                  rst_n,
  input  osct_pkg::chain_ctl_t ctl,
  input  osct_pkg::cell_t      shift_in,
  output osct_pkg::cell_t      head
);
  import osct_pkg::*;

  cell_t c [MAX_WIDTH];

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    cell_t up_w;
    cell_t dn_w;
    if (i == MAX_WIDTH - 1) begin : g_top
      assign up_w = shift_in;
    end else begin : g_mid
      assign up_w = c[i+1];
    end
    if (i == 0) begin : g_bot
      assign dn_w = '0;
    end else begin : g_up
      assign dn_w = c[i-1];
    end
    osct_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .up_i (up_w),
      .dn_i (dn_w),
      .q_o  (c[i])
    );
  end

  assign head = c[0];

endmodule
`default_nettype wire

@@ src/osct_gain.sv @@
`default_nettype none
module osct_gain (
  input  wire                                  clk,
  input  wire signed [osct_pkg::G_W-1:0]       g,
  input  wire                                  direction,
  input  wire        [osct_pkg::C_W-1:0]       penalty_c,
  input  wire        [osct_pkg::A_W-1:0]       gain_a,
  output logic signed [osct_pkg::P_W-1:0]      product
);
  import osct_pkg::*;

  logic signed [G_W-1:0]  gd;
  logic        [G_W-1:0]  mag;
  logic        [C_W:0]    pen;
  logic signed [IN_W-1:0] inner_nxt;
  logic signed [IN_W-1:0] inner_r;
  logic signed [P_W-1:0]  product_r;

  always_comb begin
    gd  = direction ? -g : g;
    mag = gd[G_W-1] ? G_W'(-gd) : G_W'(gd);
    if (gd[G_W-1]) begin
      pen = {penalty_c, 1'b0};
    end else if (gd == '0) begin
      pen = {1'b0, penalty_c};
    end else begin
      pen = '0;
    end
    inner_nxt = $signed({2'b00, mag}) - $signed({1'b0, pen});
  end

  always_ff @(posedge clk) begin
    inner_r   <= inner_nxt;
    product_r <= P_W'($signed({1'b0, gain_a})) * P_W'(inner_r);
  end

  assign product = product_r;

endmodule
`default_nettype wire
